FILE: rtl/asp_pkg.sv
// Shared types, codes and a helper function of the affine span shader.
package asp_pkg;

  localparam logic [1:0] FUNC_VERTEX = 2'd0;
  localparam logic [1:0] FUNC_TEXEL  = 2'd1;
  localparam logic [1:0] FUNC_SPAN   = 2'd2;

  localparam logic [2:0] REG_RENDER_MODE   = 3'd0;
  localparam logic [2:0] REG_FLAT_COLOR    = 3'd1;
  localparam logic [2:0] REG_FACE_BRIGHT   = 3'd2;
  localparam logic [2:0] REG_TEX_ROW_SHIFT = 3'd3;
  localparam logic [2:0] REG_TEX_U_MASK    = 3'd4;
  localparam logic [2:0] REG_TEX_V_MASK    = 3'd5;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;

  localparam logic [3:0] MUL_NONE = 4'd0;
  localparam logic [3:0] MUL_D1   = 4'd1;
  localparam logic [3:0] MUL_D2   = 4'd2;
  localparam logic [3:0] MUL_W0A  = 4'd3;
  localparam logic [3:0] MUL_W0B  = 4'd4;
  localparam logic [3:0] MUL_W1A  = 4'd5;
  localparam logic [3:0] MUL_W1B  = 4'd6;
  localparam logic [3:0] MUL_STEP = 4'd7;
  localparam logic [3:0] MUL_WLO  = 4'd8;
  localparam logic [3:0] MUL_WHI  = 4'd9;

  localparam logic [2:0] ACC_NONE  = 3'd0;
  localparam logic [2:0] ACC_LOAD  = 3'd1;
  localparam logic [2:0] ACC_ADD   = 3'd2;
  localparam logic [2:0] ACC_SUB   = 3'd3;
  localparam logic [2:0] ACC_ADDHI = 3'd4;

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_DENOM = 3'd1;
  localparam logic [2:0] ST_W0    = 3'd2;
  localparam logic [2:0] ST_W1    = 3'd3;
  localparam logic [2:0] ST_W2    = 3'd4;
  localparam logic [2:0] ST_STEP  = 3'd5;
  localparam logic [2:0] ST_ACCUM = 3'd6;

  localparam logic [23:0] HILIT_COLOR = 24'hDDAACC;

  typedef struct packed {
    logic       load_vtx;
    logic       write_tex;
    logic       load_span;
    logic [3:0] mul_op;
    logic [1:0] vtx;
    logic [1:0] attr;
    logic [2:0] acc_op;
    logic [2:0] store_op;
    logic       div_start;
    logic       pix_issue;
    logic       pix_last;
  } cmd_t;

  typedef struct packed {
    logic        span_empty;
    logic        denom_zero;
    logic        div_done;
    logic [12:0] span_len;
  } status_t;

  function automatic logic [23:0] scale_bri(input logic [23:0] c, input logic [31:0] b);
    logic [31:0] rb;
    logic [31:0] rg;
    logic [31:0] r;
    rb = {8'b0, c & 24'hFF00FF} * b;
    rg = {8'b0, c & 24'h00FF00} * b;
    r  = (rb & 32'hFF00FF00) | (rg & 32'h00FF0000);
    return r[31:8];
  endfunction

endpackage

FILE: rtl/asp_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
module asp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        active;
  logic [5:0]  cnt;
  logic [63:0] num;
  logic [63:0] rem;
  logic [63:0] mag_b;
  logic        neg;
  logic        zero_div;
  logic [64:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, num[63]};
  assign ge = rem_sh >= {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt <= '0;
      end else if (active) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend[63] ? 64'd0 - dividend : dividend;
      mag_b <= divisor[63] ? 64'd0 - divisor : divisor;
      neg <= dividend[63] ^ divisor[63];
      zero_div <= divisor == 64'd0;
      rem <= '0;
    end else if (active) begin
      rem <= ge ? 64'(rem_sh - {1'b0, mag_b}) : rem_sh[63:0];
      num <= {num[62:0], ge};
    end
  end

  assign quotient = zero_div ? 64'd0 : (neg ? 64'd0 - num : num);

endmodule

FILE: rtl/asp_datapath.sv
// Datapath: vertex and configuration registers, setup arithmetic, texture store and pixel pipe.
module asp_datapath #(
  parameter int TEX_ADDR_BITS = 16,
  parameter int TEXEL_FRAC = 5,
  parameter int ATTR_FRAC = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  asp_pkg::cmd_t       cmd,
  output asp_pkg::status_t    status,
  input  logic [1:0]          vertex_sel,
  input  logic signed [31:0]  screen_x,
  input  logic signed [31:0]  screen_y,
  input  logic signed [31:0]  tex_u,
  input  logic signed [31:0]  tex_v,
  input  logic [8:0]          vertex_bright,
  input  logic [15:0]         texel_index,
  input  logic [23:0]         texel_color,
  input  logic [11:0]         row,
  input  logic [11:0]         first_col,
  input  logic [11:0]         last_col,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output logic                result_valid,
  output logic [23:0]         pixel_addr,
  output logic [23:0]         pixel_color,
  output logic                last
);
  import asp_pkg::*;

  logic [3:0]  render_mode;
  logic [23:0] flat_color;
  logic [8:0]  face_bright;
  logic [3:0]  tex_row_shift;
  logic [14:0] tex_u_mask;
  logic [14:0] tex_v_mask;
  logic [12:0] screen_width;

  logic [31:0] px [3];
  logic [31:0] py [3];
  logic [31:0] tu [3];
  logic [31:0] tv [3];
  logic [8:0]  vb [3];

  logic [11:0] row_q;
  logic [11:0] fc_q;
  logic [11:0] lc_q;
  logic [12:0] x_q;
  logic [24:0] base_q;

  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [63:0] denom_q;
  logic [63:0] w0_q;
  logic [63:0] w1_q;
  logic [63:0] w2_q;
  logic [63:0] step_q [3];
  logic [63:0] accum_q [3];

  logic [23:0] tex_mem [2**TEX_ADDR_BITS];
  logic [23:0] tex_q;

  logic signed [33:0] sx0, sx1, sx2, sy0, sy1, sy2, fx, fy;
  logic signed [33:0] op_a, op_b, dw_sel, t_val;
  logic signed [67:0] prod_full;
  logic [63:0] w_sel;
  logic [31:0] t_src;

  logic        div_done;
  logic [63:0] quotient;

  logic [31:0] tidx_ext;
  logic [15:0] su, sv;
  logic [15:0] tcu, tcv;
  logic [14:0] cu, cv;
  logic [30:0] idx_sum;
  logic        hilit;

  logic        p1_valid, p1_last, p1_hilit;
  logic [23:0] p1_addr;
  logic [31:0] p1_bri;
  logic        p2_valid, p2_last, p2_hilit;
  logic [23:0] p2_addr;
  logic [23:0] p2_color;
  logic [31:0] p2_bri;
  logic [23:0] c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      render_mode <= '0;
      flat_color <= '0;
      face_bright <= 9'd256;
      tex_row_shift <= '0;
      tex_u_mask <= '0;
      tex_v_mask <= '0;
      screen_width <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RENDER_MODE:   render_mode <= cfg_data[3:0];
        REG_FLAT_COLOR:    flat_color <= cfg_data;
        REG_FACE_BRIGHT:   face_bright <= cfg_data[8:0];
        REG_TEX_ROW_SHIFT: tex_row_shift <= cfg_data[3:0];
        REG_TEX_U_MASK:    tex_u_mask <= cfg_data[14:0];
        REG_TEX_V_MASK:    tex_v_mask <= cfg_data[14:0];
        REG_SCREEN_WIDTH:  screen_width <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vtx) begin
      case (vertex_sel)
        2'd0, 2'd1, 2'd2: begin
          px[vertex_sel] <= screen_x;
          py[vertex_sel] <= screen_y;
          tu[vertex_sel] <= tex_u;
          tv[vertex_sel] <= tex_v;
          vb[vertex_sel] <= vertex_bright;
        end
        default: ;
      endcase
    end
    if (cmd.load_span) begin
      row_q <= row;
      fc_q <= first_col;
      lc_q <= last_col;
      x_q <= {1'b0, first_col};
      base_q <= row * screen_width;
    end else if (cmd.pix_issue) begin
      x_q <= x_q + 13'd1;
    end
  end

  assign status.span_empty = lc_q < fc_q;
  assign status.span_len = {1'b0, lc_q} - {1'b0, fc_q} + 13'd1;
  assign status.denom_zero = denom_q == 64'd0;
  assign status.div_done = div_done;

  assign sx0 = $signed({{2{px[0][31]}}, px[0]});
  assign sx1 = $signed({{2{px[1][31]}}, px[1]});
  assign sx2 = $signed({{2{px[2][31]}}, px[2]});
  assign sy0 = $signed({{2{py[0][31]}}, py[0]});
  assign sy1 = $signed({{2{py[1][31]}}, py[1]});
  assign sy2 = $signed({{2{py[2][31]}}, py[2]});
  assign fx = $signed({6'b0, fc_q, 16'b0});
  assign fy = $signed({6'b0, row_q, 16'b0});

  always_comb begin
    case (cmd.vtx)
      2'd0: begin dw_sel = sy2 - sy1; w_sel = w0_q; end
      2'd1: begin dw_sel = sy0 - sy2; w_sel = w1_q; end
      default: begin dw_sel = sy1 - sy0; w_sel = w2_q; end
    endcase
    case (cmd.vtx)
      2'd0: t_src = (cmd.attr == 2'd0) ? tu[0] : tv[0];
      2'd1: t_src = (cmd.attr == 2'd0) ? tu[1] : tv[1];
      default: t_src = (cmd.attr == 2'd0) ? tu[2] : tv[2];
    endcase
    if (cmd.attr == 2'd2) begin
      case (cmd.vtx)
        2'd0: t_val = $signed({25'b0, vb[0]});
        2'd1: t_val = $signed({25'b0, vb[1]});
        default: t_val = $signed({25'b0, vb[2]});
      endcase
    end else begin
      t_val = $signed({{2{t_src[31]}}, t_src}) >>> (16 - TEXEL_FRAC);
    end
    case (cmd.mul_op)
      MUL_D1:   begin op_a = sx2 - sx0; op_b = sy1 - sy0; end
      MUL_D2:   begin op_a = sy2 - sy0; op_b = sx1 - sx0; end
      MUL_W0A:  begin op_a = fx - sx1;  op_b = sy2 - sy1; end
      MUL_W0B:  begin op_a = fy - sy1;  op_b = sx2 - sx1; end
      MUL_W1A:  begin op_a = fx - sx2;  op_b = sy0 - sy2; end
      MUL_W1B:  begin op_a = fy - sy2;  op_b = sx0 - sx2; end
      MUL_STEP: begin op_a = dw_sel;    op_b = t_val; end
      MUL_WLO:  begin op_a = $signed({2'b0, w_sel[31:0]}); op_b = t_val; end
      MUL_WHI:  begin op_a = $signed({{2{w_sel[63]}}, w_sel[63:32]}); op_b = t_val; end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_full = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q[0] <= '0;
      step_q[1] <= '0;
      step_q[2] <= '0;
      accum_q[0] <= '0;
      accum_q[1] <= '0;
      accum_q[2] <= '0;
    end else begin
      if (cmd.store_op == ST_STEP && div_done) begin
        step_q[cmd.attr] <= quotient;
      end else if (cmd.store_op == ST_ACCUM && div_done) begin
        accum_q[cmd.attr] <= quotient;
      end else if (cmd.pix_issue) begin
        accum_q[0] <= accum_q[0] + step_q[0];
        accum_q[1] <= accum_q[1] + step_q[1];
        accum_q[2] <= accum_q[2] + step_q[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= prod_full[63:0];
    case (cmd.acc_op)
      ACC_LOAD:  acc_q <= prod_q;
      ACC_ADD:   acc_q <= acc_q + prod_q;
      ACC_SUB:   acc_q <= acc_q - prod_q;
      ACC_ADDHI: acc_q <= acc_q + {prod_q[31:0], 32'b0};
      default: ;
    endcase
    case (cmd.store_op)
      ST_DENOM: denom_q <= {{16{acc_q[63]}}, acc_q[63:16]};
      ST_W0:    w0_q <= {{16{acc_q[63]}}, acc_q[63:16]};
      ST_W1:    w1_q <= {{16{acc_q[63]}}, acc_q[63:16]};
      ST_W2:    w2_q <= denom_q - w0_q - w1_q;
      default: ;
    endcase
  end

  asp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc_q << ATTR_FRAC),
    .divisor  (denom_q),
    .done     (div_done),
    .quotient (quotient)
  );

  assign su = accum_q[0][TEXEL_FRAC +: 16];
  assign sv = accum_q[1][TEXEL_FRAC +: 16];
  assign tcu = $signed(su) >>> ATTR_FRAC;
  assign tcv = $signed(sv) >>> ATTR_FRAC;
  assign cu = tcu[14:0] & tex_u_mask;
  assign cv = tcv[14:0] & tex_v_mask;
  assign idx_sum = {16'b0, cu} + ({16'b0, cv} << tex_row_shift);
  assign tidx_ext = {16'b0, texel_index};
  assign hilit = render_mode[3] &&
                 ((x_q[2:0] == 3'd0 && row_q[2:0] == 3'd0) ||
                  (x_q[2:0] == 3'd4 && row_q[2:0] == 3'd4));

  always_ff @(posedge clk) begin
    if (cmd.write_tex) begin
      tex_mem[tidx_ext[TEX_ADDR_BITS-1:0]] <= texel_color;
    end
    tex_q <= tex_mem[idx_sum[TEX_ADDR_BITS-1:0]];
  end

  always_comb begin
    c1 = render_mode[0] ? tex_q : flat_color;
    if (render_mode[2]) begin
      c1 = scale_bri(c1, {23'b0, face_bright});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.pix_issue;
      p2_valid <= p1_valid;
      result_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_last <= cmd.pix_last;
    p1_hilit <= hilit;
    p1_addr <= 24'(base_q + {12'b0, x_q});
    p1_bri <= accum_q[2][ATTR_FRAC +: 32];
    p2_last <= p1_last;
    p2_hilit <= p1_hilit;
    p2_addr <= p1_addr;
    p2_bri <= p1_bri;
    p2_color <= p1_hilit ? HILIT_COLOR : c1;
    last <= p2_last;
    pixel_addr <= p2_addr;
    pixel_color <= (!p2_hilit && render_mode[1]) ? scale_bri(p2_color, p2_bri) : p2_color;
  end

endmodule

FILE: rtl/asp_ctrl.sv
// Controller: sequences vertex and texel loads, span setup, divisions and pixel issue.
module asp_ctrl #(
  parameter int MAX_SPAN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       func,
  output logic             busy,
  output asp_pkg::cmd_t    cmd,
  input  asp_pkg::status_t status
);
  import asp_pkg::*;

  localparam int KW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GEO  = 3'd1;
  localparam logic [2:0] S_SNUM = 3'd2;
  localparam logic [2:0] S_SDIV = 3'd3;
  localparam logic [2:0] S_ANUM = 3'd4;
  localparam logic [2:0] S_ADIV = 3'd5;
  localparam logic [2:0] S_PIX  = 3'd6;

  logic [2:0]    state, state_next;
  logic [3:0]    cnt, cnt_next;
  logic [1:0]    attr, attr_next;
  logic [KW-1:0] k, k_next;
  logic          accept;
  logic [12:0]   n_eff;
  logic          pix_end;

  assign accept = start && !busy;
  assign busy = state != S_IDLE;
  assign n_eff = (status.span_len > 13'(MAX_SPAN)) ? 13'(MAX_SPAN) : status.span_len;
  assign pix_end = {{(13 - KW){1'b0}}, k} == n_eff - 13'd1;

  always_comb begin
    cmd = '0;
    state_next = state;
    cnt_next = cnt + 4'd1;
    attr_next = attr;
    k_next = k;
    cmd.attr = attr;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        cmd.load_vtx = accept && func == FUNC_VERTEX;
        cmd.write_tex = accept && func == FUNC_TEXEL;
        cmd.load_span = accept && func == FUNC_SPAN;
        if (cmd.load_span) begin
          state_next = S_GEO;
        end
      end
      S_GEO: begin
        case (cnt)
          4'd0: cmd.mul_op = MUL_D1;
          4'd1: begin cmd.mul_op = MUL_D2; cmd.acc_op = ACC_LOAD; end
          4'd2: begin cmd.mul_op = MUL_W0A; cmd.acc_op = ACC_SUB; end
          4'd3: begin
            cmd.mul_op = MUL_W0B; cmd.acc_op = ACC_LOAD; cmd.store_op = ST_DENOM;
          end
          4'd4: begin cmd.mul_op = MUL_W1A; cmd.acc_op = ACC_SUB; end
          4'd5: begin
            cmd.mul_op = MUL_W1B; cmd.acc_op = ACC_LOAD; cmd.store_op = ST_W0;
          end
          4'd6: cmd.acc_op = ACC_SUB;
          4'd7: cmd.store_op = ST_W1;
          default: cmd.store_op = ST_W2;
        endcase
        if (cnt == 4'd0 && status.span_empty) begin
          state_next = S_IDLE;
        end else if (cnt == 4'd8) begin
          cnt_next = '0;
          attr_next = '0;
          state_next = status.denom_zero ? S_IDLE : S_SNUM;
        end
      end
      S_SNUM: begin
        cmd.vtx = cnt[1:0];
        case (cnt)
          4'd0: cmd.mul_op = MUL_STEP;
          4'd1: begin cmd.mul_op = MUL_STEP; cmd.acc_op = ACC_LOAD; end
          4'd2: begin cmd.mul_op = MUL_STEP; cmd.acc_op = ACC_ADD; end
          4'd3: cmd.acc_op = ACC_ADD;
          default: begin
            cmd.div_start = 1'b1;
            state_next = S_SDIV;
          end
        endcase
      end
      S_SDIV: begin
        cmd.store_op = ST_STEP;
        cnt_next = '0;
        if (status.div_done) begin
          state_next = S_ANUM;
        end
      end
      S_ANUM: begin
        cmd.vtx = cnt[2:1];
        case (cnt)
          4'd0: cmd.mul_op = MUL_WLO;
          4'd1: begin cmd.mul_op = MUL_WHI; cmd.acc_op = ACC_LOAD; end
          4'd2: begin cmd.mul_op = MUL_WLO; cmd.acc_op = ACC_ADDHI; end
          4'd3: begin cmd.mul_op = MUL_WHI; cmd.acc_op = ACC_ADD; end
          4'd4: begin cmd.mul_op = MUL_WLO; cmd.acc_op = ACC_ADDHI; end
          4'd5: begin cmd.mul_op = MUL_WHI; cmd.acc_op = ACC_ADD; end
          4'd6: cmd.acc_op = ACC_ADDHI;
          default: begin
            cmd.div_start = 1'b1;
            state_next = S_ADIV;
          end
        endcase
      end
      S_ADIV: begin
        cmd.store_op = ST_ACCUM;
        cnt_next = '0;
        k_next = '0;
        if (status.div_done) begin
          if (attr == 2'd2) begin
            state_next = S_PIX;
          end else begin
            attr_next = attr + 2'd1;
            state_next = S_SNUM;
          end
        end
      end
      S_PIX: begin
        cmd.pix_issue = 1'b1;
        cmd.pix_last = pix_end;
        k_next = k + KW'(1);
        if (pix_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      attr <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      attr <= attr_next;
      k <= k_next;
    end
  end

  a_span_enters_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.load_span |=> state == S_GEO)
    else $error("span request did not enter setup");

  a_last_pixel_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_last |=> state == S_IDLE)
    else $error("controller stayed busy after the last pixel");

  a_step_div_moves_on: assert property (@(posedge clk) disable iff (rst)
    (state == S_SDIV && status.div_done) |=> (state == S_ANUM && cnt == 4'd0))
    else $error("step division did not hand over to start value numerator");

  a_div_not_instant: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("division finished in one cycle");

endmodule

FILE: rtl/affine_span_shader_unit.sv
// Top level of the affine span shader: controller, datapath and ports.
//
//  Channel   Handshake                  Payload
//  request   start / busy               func, vertex_sel, vertex and texel fields, span
//  result    result_valid (one cycle)   pixel_addr, pixel_color, last
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Vertex and texel requests are stored as soon as they are accepted. A span request
// runs setup first, then issues one pixel per cycle; the 64-bit divider, one quotient
// bit per cycle and used six times per span, sets the setup length. Results pass
// through the p1, p2 and output registers. Reset is synchronous and clears all control
// state; no clearing pass is needed. The receiver cannot stall results.
module affine_span_shader_unit #(
  parameter int MAX_SPAN = 64,
  parameter int TEX_ADDR_BITS = 16,
  parameter int TEXEL_FRAC = 5,
  parameter int ATTR_FRAC = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [1:0]         vertex_sel,
  input  logic signed [31:0] screen_x,
  input  logic signed [31:0] screen_y,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic [8:0]         vertex_bright,
  input  logic [15:0]        texel_index,
  input  logic [23:0]        texel_color,
  input  logic [11:0]        row,
  input  logic [11:0]        first_col,
  input  logic [11:0]        last_col,
  output logic               result_valid,
  output logic [23:0]        pixel_addr,
  output logic [23:0]        pixel_color,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import asp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  asp_ctrl #(
    .MAX_SPAN (MAX_SPAN)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  asp_datapath #(
    .TEX_ADDR_BITS (TEX_ADDR_BITS),
    .TEXEL_FRAC    (TEXEL_FRAC),
    .ATTR_FRAC     (ATTR_FRAC)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .vertex_sel    (vertex_sel),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .vertex_bright (vertex_bright),
    .texel_index   (texel_index),
    .texel_color   (texel_color),
    .row           (row),
    .first_col     (first_col),
    .last_col      (last_col),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .pixel_addr    (pixel_addr),
    .pixel_color   (pixel_color),
    .last          (last)
  );

endmodule
